// ===== hdl/rmq_pkg.sv =====
// rmq_pkg: shared types, widths and the bit counts of the root and divide steps.
// Used by every module of rotation_matrix_to_quaternion. No dependencies.
package rmq_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW = 18;
  localparam int RW = 21;                 // radicand magnitude, < 2^20 plus sign
  localparam int SQW = RW + FRAC_BITS;    // radicand << FRAC_BITS
  localparam int SRW = (SQW + 1) / 2;     // root width
  localparam int NW = 20;                 // numerator magnitude
  localparam int QW = DW + 1;             // quotient bits kept (up to 2^18)
  localparam int DNW = SRW + 1;           // divisor width
  localparam int ROOT_STEPS = SRW;
  localparam int DIV_STEPS = QW;
  localparam logic signed [DW-1:0] QMAX = 18'sd131071;
  localparam logic signed [DW-1:0] QMIN = -18'sd131072;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0, BR_X = 2'd1, BR_Y = 2'd2, BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic [2:0][NW-1:0] num_mag;
    logic [2:0]         num_neg;
    branch_t            br;
    logic               bad;
  } meta_t;
endpackage

// ===== hdl/rmq_front.sv =====
// rmq_front: trace, branch choice, radicand and numerators; one register stage.
// Depends on rmq_pkg.
module rmq_front (
  input  logic clk,
  input  logic en,
  input  logic signed [rmq_pkg::DW-1:0] m [9],
  output logic [rmq_pkg::SQW-1:0] rad_sh,
  output rmq_pkg::meta_t meta
);
  logic signed [rmq_pkg::RW-1:0] e [9];
  logic signed [rmq_pkg::RW-1:0] tr, rad, n [3];
  rmq_pkg::branch_t br;
  logic [rmq_pkg::RW-1:0] rad_c;
  rmq_pkg::meta_t mt;

  always_comb begin
    for (int i = 0; i < 9; i++) e[i] = rmq_pkg::RW'(m[i]);
    tr = e[0] + e[4] + e[8];
    if (tr > 0) br = rmq_pkg::BR_TRACE;
    else if (e[0] > e[4] && e[0] > e[8]) br = rmq_pkg::BR_X;
    else if (e[4] > e[8]) br = rmq_pkg::BR_Y;
    else br = rmq_pkg::BR_Z;
    unique case (br)
      rmq_pkg::BR_TRACE: begin
        rad = tr;
        n[0] = e[5] - e[7]; n[1] = e[6] - e[2]; n[2] = e[1] - e[3];
      end
      rmq_pkg::BR_X: begin
        rad = e[0] - (e[4] + e[8]);
        n[0] = e[3] + e[1]; n[1] = e[6] + e[2]; n[2] = e[5] - e[7];
      end
      rmq_pkg::BR_Y: begin
        rad = e[4] - (e[8] + e[0]);
        n[0] = e[3] + e[1]; n[1] = e[5] + e[7]; n[2] = e[6] - e[2];
      end
      default: begin
        rad = e[8] - (e[0] + e[4]);
        n[0] = e[6] + e[2]; n[1] = e[5] + e[7]; n[2] = e[1] - e[3];
      end
    endcase
    rad = rad + (rmq_pkg::RW'(1) << rmq_pkg::FRAC_BITS);
    rad_c = rad[rmq_pkg::RW-1] ? '0 : rad;
    mt.br = br;
    mt.bad = rad[rmq_pkg::RW-1];
    for (int i = 0; i < 3; i++) begin
      mt.num_neg[i] = n[i][rmq_pkg::RW-1];
      mt.num_mag[i] = rmq_pkg::NW'(n[i][rmq_pkg::RW-1] ? -n[i] : n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_sh <= rmq_pkg::SQW'(rad_c) << rmq_pkg::FRAC_BITS;
      meta <= mt;
    end
  end
endmodule

// ===== hdl/rmq_sqrt.sv =====
// rmq_sqrt: pipelined restoring integer square root, one result bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [rmq_pkg::SQW-1:0] rad_sh,
  input  rmq_pkg::meta_t meta_in,
  output logic [rmq_pkg::SRW-1:0] root,
  output rmq_pkg::meta_t meta_out
);
  localparam int S = rmq_pkg::ROOT_STEPS;
  localparam int AW = 2 * S;
  logic [AW-1:0] rem [S+1];
  logic [AW-1:0] val [S+1];
  logic [S-1:0] rt [S+1];
  rmq_pkg::meta_t md [S+1];

  always_comb begin
    rem[0] = '0; rt[0] = '0; md[0] = meta_in;
    val[0] = AW'(rad_sh);
  end

  for (genvar k = 0; k < S; k++) begin : g_st
    logic [AW-1:0] r2, t;
    always_comb begin
      r2 = {rem[k][AW-3:0], val[k][AW-1:AW-2]};
      t = AW'({rt[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1] <= val[k] << 2;
        if (r2 >= t) begin
          rem[k+1] <= r2 - t; rt[k+1] <= {rt[k][S-2:0], 1'b1};
        end else begin
          rem[k+1] <= r2;     rt[k+1] <= {rt[k][S-2:0], 1'b0};
        end
        md[k+1] <= md[k];
      end
    end
  end

  assign root = rt[S];
  assign meta_out = md[S];
endmodule

// ===== hdl/rmq_div.sv =====
// rmq_div: three pipelined restoring dividers, one quotient bit per stage,
// then sign, saturation and component placement. Depends on rmq_pkg.
module rmq_div (
  input  logic clk,
  input  logic en,
  input  logic [rmq_pkg::SRW-1:0] root,
  input  rmq_pkg::meta_t meta_in,
  output logic signed [rmq_pkg::DW-1:0] q [4],
  output rmq_pkg::branch_t br,
  output logic bad
);
  localparam int S = rmq_pkg::DIV_STEPS;
  localparam int XW = rmq_pkg::NW + rmq_pkg::FRAC_BITS; // dividend width
  localparam int RMW = rmq_pkg::DNW + 1;
  logic [XW-1:0] dvd [S+1][3];
  logic [RMW-1:0] rem [S+1][3];
  logic [S-1:0] quo [S+1][3];
  logic [rmq_pkg::DNW-1:0] den [S+1];
  logic [rmq_pkg::SRW-1:0] rt [S+1];
  rmq_pkg::meta_t md [S+1];

  always_comb begin
    den[0] = {root, 1'b0};
    rt[0] = root; md[0] = meta_in;
    for (int j = 0; j < 3; j++) begin
      dvd[0][j] = XW'(meta_in.num_mag[j]) << rmq_pkg::FRAC_BITS;
      rem[0][j] = '0; quo[0][j] = '0;
    end
  end

  // Quotients of 2^19 and above saturate; the dividend bits above the
  // quotient are folded into the first remainder so only QW quotient bits
  // are produced.
  for (genvar k = 0; k < S; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1] <= den[k]; rt[k+1] <= rt[k]; md[k+1] <= md[k];
        for (int j = 0; j < 3; j++) begin
          logic [XW+RMW-1:0] r2;
          logic [XW+RMW-1:0] pre;
          if (k == 0) begin
            pre = (XW+RMW)'(dvd[0][j] >> (S - 1));
            r2 = pre;
          end else begin
            pre = '0;
            r2 = {rem[k][j], dvd[k][j][S-1-k]};
          end
          dvd[k+1][j] <= dvd[k][j];
          if (k == 0 && (pre >> 1) >= (XW+RMW)'(den[k])) begin
            rem[k+1][j] <= '0; quo[k+1][j] <= '1;   // overflow marker
          end else if (k != 0 && quo[k][j][0] && &quo[k][j]) begin
            rem[k+1][j] <= '0; quo[k+1][j] <= '1;
          end else if (r2 >= (XW+RMW)'(den[k])) begin
            rem[k+1][j] <= RMW'(r2 - (XW+RMW)'(den[k]));
            quo[k+1][j] <= {quo[k][j][S-2:0], 1'b1};
          end else begin
            rem[k+1][j] <= RMW'(r2);
            quo[k+1][j] <= {quo[k][j][S-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic signed [rmq_pkg::DW-1:0] d [3];
  logic signed [rmq_pkg::DW-1:0] half;
  logic zero;
  always_comb begin
    zero = (rt[S] == '0);
    half = rmq_pkg::DW'(rt[S] >> 1);
    if ((rt[S] >> 1) > rmq_pkg::SRW'(rmq_pkg::QMAX)) half = rmq_pkg::QMAX;
    for (int j = 0; j < 3; j++) begin
      logic [S-1:0] qq;
      qq = quo[S][j];
      if (zero) d[j] = '0;
      else if (md[S].num_neg[j])
        d[j] = (qq >= S'(131072)) ? rmq_pkg::QMIN : -rmq_pkg::DW'(qq);
      else
        d[j] = (qq > S'(131071)) ? rmq_pkg::QMAX : rmq_pkg::DW'(qq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br <= md[S].br;
      bad <= md[S].bad | zero;
      unique case (md[S].br)
        rmq_pkg::BR_TRACE: begin q[0] <= d[0]; q[1] <= d[1]; q[2] <= d[2]; q[3] <= half; end
        rmq_pkg::BR_X: begin q[0] <= half; q[1] <= d[0]; q[2] <= d[1]; q[3] <= d[2]; end
        rmq_pkg::BR_Y: begin q[0] <= d[0]; q[1] <= half; q[2] <= d[1]; q[3] <= d[2]; end
        default: begin q[0] <= d[0]; q[1] <= d[1]; q[2] <= half; q[3] <= d[2]; end
      endcase
    end
  end
endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation_matrix_to_quaternion: Q2.16 direction cosine matrix to quaternion.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
//
// Input channel: in_valid / in_stall with the nine elements m00..m22.
// Output channel: out_valid / out_stall with quat_x..quat_w, branch, invalid.
// A transaction takes place when valid is high and stall low at a clock edge.
// The pipe has 1 front stage, ROOT_STEPS (19) root stages, DIV_STEPS (19)
// divide stages and 1 output stage; one matrix per cycle while the output
// is not stalled. The stage count is set by the bit-per-stage square root
// and the three bit-per-stage dividers that run side by side.
// The whole pipe advances as one: while the output holds a result and the
// receiver stalls, every stage holds, empty slots included, and in_stall
// follows out_stall only then.
// Reset (rst, synchronous) clears the valid bits; payload is not reset.
module rotation_matrix_to_quaternion (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [17:0] quat_x, quat_y, quat_z, quat_w,
  output logic [1:0] branch,
  output logic invalid
);
  localparam int LAT = 2 + rmq_pkg::ROOT_STEPS + rmq_pkg::DIV_STEPS;
  logic [LAT-1:0] vld;
  logic en;
  logic signed [rmq_pkg::DW-1:0] m [9];
  logic [rmq_pkg::SQW-1:0] rad_sh;
  rmq_pkg::meta_t m1, m2;
  logic [rmq_pkg::SRW-1:0] root;
  logic signed [rmq_pkg::DW-1:0] q [4];
  rmq_pkg::branch_t br;

  // Pipe holds only when a finished result is blocked.
  assign en = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;
  assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  rmq_front u_front (.clk, .en, .m, .rad_sh, .meta(m1));
  rmq_sqrt u_sqrt (.clk, .en, .rad_sh, .meta_in(m1), .root, .meta_out(m2));
  rmq_div u_div (.clk, .en, .root, .meta_in(m2), .q, .br, .bad(invalid));

  assign out_valid = vld[LAT-1];
  assign quat_x = q[0];
  assign quat_y = q[1];
  assign quat_z = q[2];
  assign quat_w = q[3];
  assign branch = br;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(branch))
    else $error("blocked result changed");
  a_stall: assert property (@(posedge clk) in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && !vld[LAT-2] |=> !out_valid)
    else $error("result appeared from an empty slot");
endmodule
